// ===== rtl/core/sfd_pkg.sv =====
package sfd_pkg;

    localparam int DATA_BITS = 40;
    localparam int BYTE_W = 8;
    localparam int TEMP_W = 12;
    localparam int CFG_IDX_W = 3;

    typedef enum logic {
        CMD_PERIOD = 1'b0,
        CMD_CLOSE  = 1'b1
    } sfd_cmd_t;

    localparam logic [CFG_IDX_W-1:0] REG_ZERO_MIN = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ZERO_MAX = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ONE_MIN  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ONE_MAX  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_LIMIT    = 3'd4;

    localparam logic [BYTE_W-1:0] ZERO_MIN_RST = 8'd70;
    localparam logic [BYTE_W-1:0] ZERO_MAX_RST = 8'd90;
    localparam logic [BYTE_W-1:0] ONE_MIN_RST  = 8'd115;
    localparam logic [BYTE_W-1:0] ONE_MAX_RST  = 8'd135;
    localparam logic [BYTE_W-1:0] LIMIT_RST    = 8'd3;

    typedef struct packed {
        logic [BYTE_W-1:0] zero_min;
        logic [BYTE_W-1:0] zero_max;
        logic [BYTE_W-1:0] one_min;
        logic [BYTE_W-1:0] one_max;
        logic [BYTE_W-1:0] fault_limit;
    } sfd_cfg_t;

    typedef struct packed {
        logic [DATA_BITS-1:0] bits;
        logic                 complete;
        logic                 bad_bit;
    } sfd_frame_t;

    typedef struct packed {
        logic              sensor_fault;
        logic [BYTE_W-1:0] bad_frame_count;
        logic              frame_good;
        logic [TEMP_W-1:0] temperature_tenths;
        logic [BYTE_W-1:0] humidity;
    } sfd_result_t;

    localparam int RESULT_W = $bits(sfd_result_t);
    localparam int TDATA_W = ((RESULT_W + 7) / 8) * 8;

endpackage

// ===== rtl/core/sfd_cfg_regs.sv =====
module sfd_cfg_regs (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [4:0]               paddr,
    input  logic [31:0]              pwdata,
    output logic [31:0]              prdata,
    output logic                     pready,
    output sfd_pkg::sfd_cfg_t        cfg
);

    sfd_pkg::sfd_cfg_t cfg_reg;
    sfd_pkg::sfd_cfg_t cfg_next;
    logic [sfd_pkg::CFG_IDX_W-1:0] reg_idx;
    logic [sfd_pkg::BYTE_W-1:0] wr_byte;
    logic wr_en;

    assign pready = 1'b1;
    assign reg_idx = paddr[4:2];
    assign wr_byte = pwdata[sfd_pkg::BYTE_W-1:0];
    assign wr_en = psel && penable && pwrite && pready;

    always_comb begin
        cfg_next = cfg_reg;
        if (wr_en) begin
            unique case (reg_idx)
                sfd_pkg::REG_ZERO_MIN: cfg_next.zero_min    = wr_byte;
                sfd_pkg::REG_ZERO_MAX: cfg_next.zero_max    = wr_byte;
                sfd_pkg::REG_ONE_MIN:  cfg_next.one_min     = wr_byte;
                sfd_pkg::REG_ONE_MAX:  cfg_next.one_max     = wr_byte;
                sfd_pkg::REG_LIMIT:    cfg_next.fault_limit = wr_byte;
                default:               cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.zero_min    <= sfd_pkg::ZERO_MIN_RST;
            cfg_reg.zero_max    <= sfd_pkg::ZERO_MAX_RST;
            cfg_reg.one_min     <= sfd_pkg::ONE_MIN_RST;
            cfg_reg.one_max     <= sfd_pkg::ONE_MAX_RST;
            cfg_reg.fault_limit <= sfd_pkg::LIMIT_RST;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    always_comb begin
        unique case (reg_idx)
            sfd_pkg::REG_ZERO_MIN: prdata = {24'd0, cfg_reg.zero_min};
            sfd_pkg::REG_ZERO_MAX: prdata = {24'd0, cfg_reg.zero_max};
            sfd_pkg::REG_ONE_MIN:  prdata = {24'd0, cfg_reg.one_min};
            sfd_pkg::REG_ONE_MAX:  prdata = {24'd0, cfg_reg.one_max};
            sfd_pkg::REG_LIMIT:    prdata = {24'd0, cfg_reg.fault_limit};
            default:               prdata = 32'd0;
        endcase
    end

    assign cfg = cfg_reg;

endmodule

// ===== rtl/core/sfd_frame_acc.sv =====
module sfd_frame_acc #(
    parameter int SKIP_PERIODS = 3
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  sfd_pkg::sfd_cfg_t          cfg,
    input  logic                       take_period,
    input  logic                       close_frame,
    input  logic [sfd_pkg::BYTE_W-1:0] period,
    output sfd_pkg::sfd_frame_t        frame
);

    localparam int FrameEdges = SKIP_PERIODS + sfd_pkg::DATA_BITS;
    localparam int IdxW = $clog2(FrameEdges + 1);

    logic [IdxW-1:0] edge_index_reg;
    logic [IdxW-1:0] edge_index_next;
    logic [sfd_pkg::DATA_BITS-1:0] shift_reg;
    logic [sfd_pkg::DATA_BITS-1:0] shift_next;
    logic bad_bit_reg;
    logic bad_bit_next;
    logic in_zero;
    logic in_one;
    logic frame_full;
    logic in_data;

    assign in_zero = (period > cfg.zero_min) && (period < cfg.zero_max);
    assign in_one = (period > cfg.one_min) && (period < cfg.one_max);
    assign frame_full = (edge_index_reg == IdxW'(FrameEdges));
    assign in_data = (edge_index_reg >= IdxW'(SKIP_PERIODS));

    always_comb begin
        edge_index_next = edge_index_reg;
        shift_next = shift_reg;
        bad_bit_next = bad_bit_reg;
        if (close_frame) begin
            edge_index_next = '0;
            shift_next = '0;
            bad_bit_next = 1'b0;
        end else if (take_period && !frame_full) begin
            edge_index_next = edge_index_reg + IdxW'(1);
            if (in_data) begin
                // A period that fits both windows counts as a zero bit.
                shift_next = {shift_reg[sfd_pkg::DATA_BITS-2:0], !in_zero && in_one};
                if (!in_zero && !in_one) begin
                    bad_bit_next = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            edge_index_reg <= '0;
            shift_reg <= '0;
            bad_bit_reg <= 1'b0;
        end else begin
            edge_index_reg <= edge_index_next;
            shift_reg <= shift_next;
            bad_bit_reg <= bad_bit_next;
        end
    end

    assign frame.bits = shift_reg;
    assign frame.complete = frame_full;
    assign frame.bad_bit = bad_bit_reg;

endmodule

// ===== rtl/core/sfd_decode.sv =====
module sfd_decode (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic [sfd_pkg::BYTE_W-1:0] fault_limit,
    input  logic                       close_frame,
    input  sfd_pkg::sfd_frame_t        frame,
    output logic                       out_free,
    output logic                       out_valid,
    input  logic                       out_ready,
    output sfd_pkg::sfd_result_t       result
);

    logic [sfd_pkg::BYTE_W-1:0] h_int;
    logic [sfd_pkg::BYTE_W-1:0] h_frac;
    logic [sfd_pkg::BYTE_W-1:0] t_int;
    logic [sfd_pkg::BYTE_W-1:0] t_frac;
    logic [sfd_pkg::BYTE_W-1:0] sum_byte;
    logic [sfd_pkg::BYTE_W+1:0] total;
    logic good;
    logic [sfd_pkg::TEMP_W-1:0] temp_calc;

    logic [sfd_pkg::BYTE_W-1:0] humidity_reg;
    logic [sfd_pkg::BYTE_W-1:0] humidity_next;
    logic [sfd_pkg::TEMP_W-1:0] temp_reg;
    logic [sfd_pkg::TEMP_W-1:0] temp_next;
    logic [sfd_pkg::BYTE_W-1:0] bad_count_reg;
    logic [sfd_pkg::BYTE_W-1:0] bad_count_next;
    logic fault_reg;
    logic fault_next;
    logic out_valid_reg;
    logic out_valid_next;
    sfd_pkg::sfd_result_t result_reg;
    sfd_pkg::sfd_result_t result_next;

    assign h_int = frame.bits[39:32];
    assign h_frac = frame.bits[31:24];
    assign t_int = frame.bits[23:16];
    assign t_frac = frame.bits[15:8];
    assign sum_byte = frame.bits[7:0];
    assign total = 10'(h_int) + 10'(h_frac) + 10'(t_int) + 10'(t_frac);
    assign good = frame.complete && !frame.bad_bit
        && (total[sfd_pkg::BYTE_W-1:0] == sum_byte);
    assign temp_calc = 12'({t_int, 3'b000}) + 12'({t_int, 1'b0}) + 12'(t_frac);

    always_comb begin
        humidity_next = humidity_reg;
        temp_next = temp_reg;
        bad_count_next = bad_count_reg;
        fault_next = fault_reg;
        if (close_frame) begin
            if (good) begin
                humidity_next = h_int;
                temp_next = temp_calc;
                bad_count_next = '0;
                fault_next = 1'b0;
            end else begin
                if (bad_count_reg != 8'hFF) begin
                    bad_count_next = bad_count_reg + 8'd1;
                end
                if (bad_count_next >= fault_limit) begin
                    humidity_next = '0;
                    temp_next = '0;
                    fault_next = 1'b1;
                end
            end
        end
    end

    always_comb begin
        result_next = result_reg;
        out_valid_next = out_valid_reg && !out_ready;
        if (close_frame) begin
            out_valid_next = 1'b1;
            result_next.humidity = humidity_next;
            result_next.temperature_tenths = temp_next;
            result_next.frame_good = good;
            result_next.bad_frame_count = bad_count_next;
            result_next.sensor_fault = fault_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            humidity_reg <= '0;
            temp_reg <= '0;
            bad_count_reg <= '0;
            fault_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            humidity_reg <= humidity_next;
            temp_reg <= temp_next;
            bad_count_reg <= bad_count_next;
            fault_reg <= fault_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        result_reg <= result_next;
    end

    assign out_free = !out_valid_reg || out_ready;
    assign out_valid = out_valid_reg;
    assign result = result_reg;

endmodule

// ===== rtl/core/single_wire_sensor_frame_decoder_unit.sv =====
// A close request waits in the input register until the output is free; its result
// is then registered into the result register on m_tdata. Period requests produce no
// result and update the frame registers. Throughput: one request per cycle while no
// close request waits; only an unconsumed result stalls a following close request.
// Reset (aresetn low, synchronous) clears the frame, readings, counters,
// fault and pending requests and restores the register defaults.
module single_wire_sensor_frame_decoder_unit #(
    parameter int SKIP_PERIODS = 3
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,  // [7:0] period
    input  logic [0:0]  s_tuser,  // [0] command
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [sfd_pkg::TDATA_W-1:0] m_tdata
    // m_tdata: [7:0] humidity, [19:8] temperature_tenths, [20] frame_good,
    // [28:21] bad_frame_count, [29] sensor_fault, [31:30] zero
);

    sfd_pkg::sfd_cfg_t cfg;
    sfd_pkg::sfd_frame_t frame;
    sfd_pkg::sfd_result_t result;

    logic in_valid_reg;
    logic in_valid_next;
    sfd_pkg::sfd_cmd_t in_cmd_reg;
    logic [sfd_pkg::BYTE_W-1:0] in_period_reg;
    logic out_free;
    logic proceed;
    logic take_period;
    logic close_frame;
    logic s_fire;

    sfd_cfg_regs u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    assign proceed = in_valid_reg && ((in_cmd_reg == sfd_pkg::CMD_PERIOD) || out_free);
    assign take_period = proceed && (in_cmd_reg == sfd_pkg::CMD_PERIOD);
    assign close_frame = proceed && (in_cmd_reg == sfd_pkg::CMD_CLOSE);
    assign s_tready = !in_valid_reg || proceed;
    assign s_fire = s_tvalid && s_tready;
    assign in_valid_next = s_fire || (in_valid_reg && !proceed);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            in_cmd_reg <= sfd_pkg::sfd_cmd_t'(s_tuser[0]);
            in_period_reg <= s_tdata;
        end
    end

    sfd_frame_acc #(
        .SKIP_PERIODS (SKIP_PERIODS)
    ) u_frame (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg         (cfg),
        .take_period (take_period),
        .close_frame (close_frame),
        .period      (in_period_reg),
        .frame       (frame)
    );

    sfd_decode u_decode (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .fault_limit (cfg.fault_limit),
        .close_frame (close_frame),
        .frame       (frame),
        .out_free    (out_free),
        .out_valid   (m_tvalid),
        .out_ready   (m_tready),
        .result      (result)
    );

    assign m_tdata = sfd_pkg::TDATA_W'(result);

endmodule

// ===== rtl/core/sfd_checker.sv =====
module sfd_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [31:0] m_tdata
);

    // A waiting result keeps its contents until it is taken.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

    // A good frame clears the error count and the fault.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[20] |-> !m_tdata[29] && (m_tdata[28:21] == 8'd0))
        else $error("good frame left count or fault set");

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tdata[20] |-> (m_tdata[28:21] != 8'd0))
        else $error("bad frame with zero count");

    // While the fault is raised the readings stay zero.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[29] |-> (m_tdata[19:0] == 20'd0))
        else $error("readings not zero under fault");

endmodule

bind single_wire_sensor_frame_decoder_unit sfd_checker u_sfd_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

// ===== sim/tb_single_wire_sensor_frame_decoder_unit.sv =====
`timescale 1ns / 1ps

module tb_single_wire_sensor_frame_decoder_unit;

    localparam int SKIP = 3;
    localparam int FRAME_EDGES = SKIP + sfd_pkg::DATA_BITS;
    localparam int QUIET_LIMIT = 2000;
    localparam int SETTLE_CYCLES = 4;
    localparam int ITEM_TARGET = 960;
    localparam logic [sfd_pkg::CFG_IDX_W-1:0] REG_SPARE_LO = 3'd5;
    localparam logic [sfd_pkg::CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

    typedef enum logic [1:0] {
        PK_ZERO,
        PK_ONE,
        PK_BAD
    } period_kind_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic psel = 1'b0;
    logic penable = 1'b0;
    logic pwrite = 1'b0;
    logic [4:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic pready;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [7:0] s_tdata = '0;
    logic [0:0] s_tuser = '0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [sfd_pkg::TDATA_W-1:0] m_tdata;

    sfd_pkg::sfd_cfg_t cfg;
    int edge_cnt;
    logic [sfd_pkg::DATA_BITS-1:0] frame_bits;
    logic frame_bad;
    logic [7:0] bad_frames;
    logic [7:0] hum_reg;
    logic [11:0] temp_reg;
    logic fault_reg;

    sfd_pkg::sfd_result_t expected_readings[$];
    int request_cnt = 0;
    int reading_cnt = 0;
    int mismatch_cnt = 0;
    int quiet_cycles = 0;
    int stall_cycles = 0;
    logic steady = 1'b0;

    single_wire_sensor_frame_decoder_unit #(
        .SKIP_PERIODS(SKIP)
    ) DUT (
        .aclk(aclk),
        .aresetn(aresetn),
        .psel(psel),
        .penable(penable),
        .pwrite(pwrite),
        .paddr(paddr),
        .pwdata(pwdata),
        .prdata(prdata),
        .pready(pready),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata(s_tdata),
        .s_tuser(s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata)
    );

    always #1 aclk = ~aclk;

    function automatic period_kind_t classify(logic [7:0] p);
        if (p > cfg.zero_min && p < cfg.zero_max) return PK_ZERO;
        if (p > cfg.one_min && p < cfg.one_max) return PK_ONE;
        return PK_BAD;
    endfunction

    function automatic logic [7:0] pick_period(period_kind_t want);
        int n;
        int k;
        n = 0;
        for (int i = 0; i < 256; i++) begin
            if (classify(8'(i)) == want) n++;
        end
        if (n == 0) return 8'($urandom_range(255));
        k = $urandom_range(n - 1);
        for (int i = 0; i < 256; i++) begin
            if (classify(8'(i)) == want) begin
                if (k == 0) return 8'(i);
                k--;
            end
        end
        return 8'd0;
    endfunction

    function automatic void reset_model();
        cfg.zero_min = sfd_pkg::ZERO_MIN_RST;
        cfg.zero_max = sfd_pkg::ZERO_MAX_RST;
        cfg.one_min = sfd_pkg::ONE_MIN_RST;
        cfg.one_max = sfd_pkg::ONE_MAX_RST;
        cfg.fault_limit = sfd_pkg::LIMIT_RST;
        edge_cnt = 0;
        frame_bits = '0;
        frame_bad = 1'b0;
        bad_frames = '0;
        hum_reg = '0;
        temp_reg = '0;
        fault_reg = 1'b0;
    endfunction

    function automatic void predict_request(sfd_pkg::sfd_cmd_t cmd, logic [7:0] p);
        logic [7:0] h_int;
        logic [7:0] h_frac;
        logic [7:0] t_int;
        logic [7:0] t_frac;
        logic [7:0] chk_byte;
        logic [7:0] total;
        logic ok;
        period_kind_t k;
        sfd_pkg::sfd_result_t r;
        if (cmd == sfd_pkg::CMD_PERIOD) begin
            if (edge_cnt < FRAME_EDGES) begin
                if (edge_cnt >= SKIP) begin
                    k = classify(p);
                    if (k == PK_BAD) frame_bad = 1'b1;
                    frame_bits = {frame_bits[sfd_pkg::DATA_BITS-2:0], k == PK_ONE};
                end
                edge_cnt++;
            end
            return;
        end
        h_int = frame_bits[39:32];
        h_frac = frame_bits[31:24];
        t_int = frame_bits[23:16];
        t_frac = frame_bits[15:8];
        chk_byte = frame_bits[7:0];
        total = h_int + h_frac + t_int + t_frac;
        ok = (edge_cnt == FRAME_EDGES) && !frame_bad && (total == chk_byte);
        if (ok) begin
            hum_reg = h_int;
            temp_reg = 12'(t_int * 10 + t_frac);
            bad_frames = '0;
            fault_reg = 1'b0;
        end else begin
            if (bad_frames != 8'hFF) bad_frames++;
            if (bad_frames >= cfg.fault_limit) begin
                hum_reg = '0;
                temp_reg = '0;
                fault_reg = 1'b1;
            end
        end
        edge_cnt = 0;
        frame_bits = '0;
        frame_bad = 1'b0;
        r.humidity = hum_reg;
        r.temperature_tenths = temp_reg;
        r.frame_good = ok;
        r.bad_frame_count = bad_frames;
        r.sensor_fault = fault_reg;
        expected_readings.push_back(r);
    endfunction

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (stall_cycles > 0) begin
            m_tready <= 1'b0;
            stall_cycles--;
        end else if (steady) begin
            m_tready <= 1'b1;
        end else begin
            m_tready <= ($urandom_range(99) >= 17);
        end
    end

    always @(posedge aclk) begin : reading_check
        sfd_pkg::sfd_result_t got;
        sfd_pkg::sfd_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got = m_tdata[sfd_pkg::RESULT_W-1:0];
            reading_cnt++;
            if (expected_readings.size() == 0) begin
                mismatch_cnt++;
                if (mismatch_cnt <= 10) $display("Unexpected result: %h", got);
            end else begin
                want = expected_readings.pop_front();
                if (got.humidity !== want.humidity
                        || got.temperature_tenths !== want.temperature_tenths
                        || got.frame_good !== want.frame_good
                        || got.bad_frame_count !== want.bad_frame_count
                        || got.sensor_fault !== want.sensor_fault) begin
                    mismatch_cnt++;
                    if (mismatch_cnt <= 10) begin
                        $display("Mismatch at %0t: expected hum %0d temp %0d good %0b bad %0d fault %0b",
                                 $realtime, want.humidity, want.temperature_tenths,
                                 want.frame_good, want.bad_frame_count, want.sensor_fault);
                        $display("                 actual hum %0d temp %0d good %0b bad %0d fault %0b",
                                 got.humidity, got.temperature_tenths, got.frame_good,
                                 got.bad_frame_count, got.sensor_fault);
                    end
                end
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)
                || (psel && penable)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("** single_wire_sensor_frame_decoder_unit: FAILED **");
                $finish;
            end
        end
    end

    task automatic send_request(input sfd_pkg::sfd_cmd_t cmd, input logic [7:0] p);
        while (!steady && $urandom_range(99) < 17) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= p;
        s_tuser <= cmd;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        request_cnt++;
        predict_request(cmd, p);
    endtask

    task automatic send_close();
        send_request(sfd_pkg::CMD_CLOSE, 8'($urandom_range(255)));
    endtask

    task automatic send_periods(input logic [39:0] word, input int count, input int bad_pos);
        logic [7:0] p;
        int d;
        for (int i = 0; i < count; i++) begin
            d = i - SKIP;
            if (d < 0 || d >= sfd_pkg::DATA_BITS) p = 8'($urandom_range(255));
            else if (d == bad_pos) p = pick_period(PK_BAD);
            else p = pick_period(word[sfd_pkg::DATA_BITS-1-d] ? PK_ONE : PK_ZERO);
            send_request(sfd_pkg::CMD_PERIOD, p);
        end
    endtask

    function automatic logic [39:0] make_word(input logic [7:0] h_int, input logic [7:0] h_frac,
                                              input logic [7:0] t_int, input logic [7:0] t_frac);
        logic [7:0] chk_byte;
        chk_byte = h_int + h_frac + t_int + t_frac;
        return {h_int, h_frac, t_int, t_frac, chk_byte};
    endfunction

    function automatic logic [39:0] random_word();
        return make_word(8'($urandom_range(255)), 8'($urandom_range(255)),
                         8'($urandom_range(255)), 8'($urandom_range(255)));
    endfunction

    task automatic settle();
        s_tvalid <= 1'b0;
        while (expected_readings.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic set_reg(input logic [sfd_pkg::CFG_IDX_W-1:0] idx, input logic [7:0] value);
        settle();
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= {24'($urandom), value};
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            sfd_pkg::REG_ZERO_MIN: cfg.zero_min = value;
            sfd_pkg::REG_ZERO_MAX: cfg.zero_max = value;
            sfd_pkg::REG_ONE_MIN:  cfg.one_min = value;
            sfd_pkg::REG_ONE_MAX:  cfg.one_max = value;
            sfd_pkg::REG_LIMIT:    cfg.fault_limit = value;
            default: ;
        endcase
    endtask

    task automatic set_windows(input logic [7:0] zmin, input logic [7:0] zmax,
                               input logic [7:0] omin, input logic [7:0] omax);
        set_reg(sfd_pkg::REG_ZERO_MIN, zmin);
        set_reg(sfd_pkg::REG_ZERO_MAX, zmax);
        set_reg(sfd_pkg::REG_ONE_MIN, omin);
        set_reg(sfd_pkg::REG_ONE_MAX, omax);
    endtask

    task automatic test_default_frames();
        send_periods(make_word(8'h00, 8'h00, 8'h00, 8'h00), FRAME_EDGES, -1);
        send_close();
        send_periods(make_word(8'hFF, 8'hFF, 8'hFF, 8'hFF), FRAME_EDGES, -1);
        send_request(sfd_pkg::CMD_PERIOD, 8'h00);
        send_request(sfd_pkg::CMD_PERIOD, 8'hFF);
        send_close();
        send_periods(make_word(8'd55, 8'd0, 8'd23, 8'd7), FRAME_EDGES, -1);
        send_close();
    endtask

    task automatic test_bad_frames();
        send_periods(random_word(), FRAME_EDGES, 17);
        send_close();
        send_periods(random_word() ^ 40'h1, FRAME_EDGES, -1);
        send_close();
        send_periods(random_word(), FRAME_EDGES - 1, -1);
        send_close();
        send_close();
        send_periods(random_word(), FRAME_EDGES, -1);
        send_close();
    endtask

    task automatic test_window_extremes();
        set_windows(8'd0, 8'd255, 8'd0, 8'd255);
        send_periods(40'h0, FRAME_EDGES, -1);
        send_close();
        send_periods(40'h0, FRAME_EDGES, 5);
        send_close();
        set_windows(8'd255, 8'd0, 8'd0, 8'd255);
        send_periods(make_word(8'hFF, 8'hFF, 8'hFF, 8'hFF), FRAME_EDGES, -1);
        send_close();
        set_windows(8'd70, 8'd130, 8'd100, 8'd140);
        send_periods(random_word(), FRAME_EDGES, -1);
        send_close();
        set_windows(sfd_pkg::ZERO_MIN_RST, sfd_pkg::ZERO_MAX_RST,
                    sfd_pkg::ONE_MIN_RST, sfd_pkg::ONE_MAX_RST);
    endtask

    task automatic test_fault_limit();
        set_reg(sfd_pkg::REG_LIMIT, 8'd1);
        send_close();
        send_periods(random_word(), FRAME_EDGES, -1);
        send_close();
        set_reg(REG_SPARE_LO, 8'd0);
        set_reg(REG_SPARE_HI, 8'hFF);
        set_reg(sfd_pkg::REG_LIMIT, 8'd2);
        send_close();
        send_close();
        send_close();
    endtask

    task automatic test_count_saturation();
        set_reg(sfd_pkg::REG_LIMIT, 8'd255);
        steady = 1'b1;
        repeat (258) send_close();
        steady = 1'b0;
        send_periods(random_word(), FRAME_EDGES, -1);
        send_close();
        set_reg(sfd_pkg::REG_LIMIT, sfd_pkg::LIMIT_RST);
    endtask

    task automatic test_output_stall();
        settle();
        stall_cycles = 300;
        send_periods(random_word(), FRAME_EDGES, -1);
        send_close();
        repeat (8) begin
            send_request(sfd_pkg::CMD_PERIOD, 8'($urandom_range(255)));
            send_close();
        end
        settle();
    endtask

    task automatic randomize_config();
        int zmin;
        int omin;
        int r;
        r = $urandom_range(99);
        if (r < 25) begin
            set_windows(sfd_pkg::ZERO_MIN_RST, sfd_pkg::ZERO_MAX_RST,
                        sfd_pkg::ONE_MIN_RST, sfd_pkg::ONE_MAX_RST);
        end else begin
            zmin = $urandom_range(0, 180);
            omin = (r < 45) ? zmin + $urandom_range(0, 30) : $urandom_range(0, 200);
            set_windows(8'(zmin), 8'((zmin + $urandom_range(2, 60)) > 255 ? 255
                                     : zmin + $urandom_range(2, 60)),
                        8'(omin), 8'((omin + 60) > 255 ? 255 : omin + $urandom_range(2, 60)));
        end
        r = $urandom_range(99);
        if (r < 50) set_reg(sfd_pkg::REG_LIMIT, 8'($urandom_range(1, 4)));
        else if (r < 85) set_reg(sfd_pkg::REG_LIMIT, 8'($urandom_range(5, 40)));
        else set_reg(sfd_pkg::REG_LIMIT, (r < 92) ? 8'd1 : 8'd255);
    endtask

    task automatic random_frame();
        int r;
        r = $urandom_range(99);
        if (r < 60) begin
            send_periods(random_word(), FRAME_EDGES, -1);
        end else if (r < 67) begin
            send_periods(random_word() ^ 40'($urandom_range(1, 255)), FRAME_EDGES, -1);
        end else if (r < 75) begin
            send_periods(random_word(), FRAME_EDGES, $urandom_range(sfd_pkg::DATA_BITS - 1));
        end else if (r < 83) begin
            send_periods(random_word(), $urandom_range(0, FRAME_EDGES - 1), -1);
        end else if (r < 89) begin
            send_periods(random_word(), FRAME_EDGES + $urandom_range(1, 12), -1);
        end else if (r < 95) begin
            repeat ($urandom_range(0, 50)) begin
                send_request(sfd_pkg::CMD_PERIOD, 8'($urandom_range(255)));
            end
        end
        send_close();
    endtask

    task automatic test_random_traffic();
        int phase;
        phase = 0;
        while (request_cnt < ITEM_TARGET) begin
            if (phase % 4 == 3) settle();
            else randomize_config();
            steady = (phase == 2);
            repeat (2) random_frame();
            phase++;
        end
        steady = 1'b0;
    endtask

    initial begin
        reset_model();
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_default_frames();
        test_bad_frames();
        test_window_extremes();
        test_fault_limit();
        test_count_saturation();
        test_output_stall();
        test_random_traffic();
        settle();
        repeat (10) @(posedge aclk);
        if (mismatch_cnt == 0) begin
            $display("** single_wire_sensor_frame_decoder_unit: PASSED **");
        end else begin
            $display("** single_wire_sensor_frame_decoder_unit: FAILED **");
        end
        $finish;
    end

endmodule
